[rtl/core/jce_pkg.sv]
package jce_pkg;

   // ASCII characters used by the escape sequences
   localparam logic [6:0] CH_BSLASH = 7'h5C;
   localparam logic [6:0] CH_QUOTE  = 7'h22;
   localparam logic [6:0] CH_U      = 7'h75;
   localparam logic [6:0] CH_B      = 7'h62;
   localparam logic [6:0] CH_F      = 7'h66;
   localparam logic [6:0] CH_N      = 7'h6E;
   localparam logic [6:0] CH_R      = 7'h72;
   localparam logic [6:0] CH_T      = 7'h74;

   // code points with a short escape
   localparam logic [20:0] CP_BS    = 21'h00008;
   localparam logic [20:0] CP_TAB   = 21'h00009;
   localparam logic [20:0] CP_LF    = 21'h0000A;
   localparam logic [20:0] CP_FF    = 21'h0000C;
   localparam logic [20:0] CP_CR    = 21'h0000D;
   localparam logic [20:0] CP_QUOTE = 21'h00022;
   localparam logic [20:0] CP_BSL   = 21'h0005C;

   // surrogate arithmetic
   localparam logic [20:0] CP_BMP_MAX   = 21'h00FFFF;
   localparam logic [20:0] CP_SUPP_BASE = 21'h010000;
   localparam logic [15:0] SURR_HI_BASE = 16'hD800;
   localparam logic [15:0] SURR_LO_BASE = 16'hDC00;

   // sequence lengths
   localparam logic [3:0] LEN_SHORT = 4'd2;
   localparam logic [3:0] LEN_U16   = 4'd6;
   localparam logic [3:0] LEN_PAIR  = 4'd12;

   // character position inside one \uXXXX group
   localparam logic [2:0] POS_BSLASH = 3'd0;
   localparam logic [2:0] POS_U      = 3'd1;
   localparam logic [2:0] POS_HEX3   = 3'd2;
   localparam logic [2:0] POS_HEX2   = 3'd3;
   localparam logic [2:0] POS_HEX1   = 3'd4;
   localparam logic [2:0] POS_HEX0   = 3'd5;

   typedef enum logic [1:0] {
      KIND_SHORT,
      KIND_U16,
      KIND_PAIR
   } kind_type;

   // classified word, as held in the queue
   typedef struct packed {
      kind_type    kind;
      logic [6:0]  short_ch;
      logic [15:0] hi;
      logic [15:0] lo;
   } desc_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

   function automatic logic [6:0] hex_char(input logic [3:0] nib);
      logic [6:0] ext;
      ext = {3'b000, nib};
      if (nib < 4'd10)
         return 7'h30 + ext;
      else
         return 7'h37 + ext;
   endfunction

   function automatic logic [3:0] seq_len(input kind_type kind);
      logic [3:0] len;
      unique case (kind)
         KIND_SHORT: len = LEN_SHORT;
         KIND_U16:   len = LEN_U16;
         KIND_PAIR:  len = LEN_PAIR;
         default:    len = LEN_U16;
      endcase
      return len;
   endfunction

endpackage

[rtl/core/jce_front.sv]
module jce_front (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [20:0]               req_code_point,
   input  jce_pkg::queue_status_type q_status,
   output logic                      push,
   output jce_pkg::desc_type         push_desc
);
   import jce_pkg::*;

   logic     valid_ff, valid_in;
   desc_type desc_ff, desc_in;
   logic [6:0]  short_ch;
   logic [20:0] supp;

   // short escape lookup
   always_comb begin
      unique case (req_code_point)
         CP_QUOTE: short_ch = CH_QUOTE;
         CP_BSL:   short_ch = CH_BSLASH;
         CP_BS:    short_ch = CH_B;
         CP_FF:    short_ch = CH_F;
         CP_LF:    short_ch = CH_N;
         CP_CR:    short_ch = CH_R;
         CP_TAB:   short_ch = CH_T;
         default:  short_ch = 7'd0;
      endcase
   end

   // classify and split into surrogates
   always_comb begin
      supp = req_code_point - CP_SUPP_BASE;
      desc_in.short_ch = short_ch;
      if (short_ch != 7'd0) begin
         desc_in.kind = KIND_SHORT;
         desc_in.hi   = req_code_point[15:0];
         desc_in.lo   = req_code_point[15:0];
      end else if (req_code_point <= CP_BMP_MAX) begin
         desc_in.kind = KIND_U16;
         desc_in.hi   = req_code_point[15:0];
         desc_in.lo   = req_code_point[15:0];
      end else begin
         desc_in.kind = KIND_PAIR;
         desc_in.hi   = SURR_HI_BASE + {5'd0, supp[20:10]};
         desc_in.lo   = SURR_LO_BASE | {6'd0, supp[9:0]};
      end
   end

   // one-word input register, drains into the queue
   assign push      = valid_ff && !q_status.full;
   assign push_desc = desc_ff;
   assign req_stall = valid_ff && q_status.full;
   assign valid_in  = req_stall ? valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_valid && !req_stall) begin
         desc_ff <= desc_in;
      end
   end

endmodule

[rtl/core/jce_queue.sv]
module jce_queue #(
   parameter int DEPTH = 2
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  jce_pkg::desc_type         push_desc,
   input  logic                      pop,
   output jce_pkg::desc_type         pop_desc,
   output jce_pkg::queue_status_type q_status
);
   import jce_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

   desc_type         mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign q_status.full  = (count_ff == FULL_CNT);
   assign q_status.empty = (count_ff == '0);
   assign do_push  = push && !q_status.full;
   assign do_pop   = pop && !q_status.empty;
   assign pop_desc = mem_ff[rd_ptr_ff];

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push)
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (do_pop)
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (do_push && !do_pop)
         count_in = count_ff + 1'b1;
      else if (do_pop && !do_push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_desc;
      end
   end

endmodule

[rtl/core/jce_back.sv]
module jce_back (
   input  logic                      clock,
   input  logic                      reset,
   input  jce_pkg::queue_status_type q_status,
   input  jce_pkg::desc_type         pop_desc,
   output logic                      pop,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [6:0]                rsp_out_char,
   output logic [3:0]                rsp_seq_length,
   output logic                      rsp_last
);
   import jce_pkg::*;

   logic       busy_ff, busy_in;
   desc_type   cur_ff;
   logic [2:0] pos_ff, pos_in;
   logic       half_ff, half_in;
   logic       fire, is_last, load;
   logic [15:0] val;

   assign fire = busy_ff && !rsp_stall;

   // end of sequence detect
   always_comb begin
      unique case (cur_ff.kind)
         KIND_SHORT: is_last = (pos_ff == POS_U);
         KIND_U16:   is_last = (pos_ff == POS_HEX0);
         KIND_PAIR:  is_last = half_ff && (pos_ff == POS_HEX0);
         default:    is_last = 1'b1;
      endcase
   end

   assign load = !q_status.empty && (!busy_ff || (fire && is_last));
   assign pop  = load;

   // character select
   assign val = half_ff ? cur_ff.lo : cur_ff.hi;
   always_comb begin
      unique case (pos_ff)
         POS_BSLASH: rsp_out_char = CH_BSLASH;
         POS_U:      rsp_out_char = (cur_ff.kind == KIND_SHORT) ? cur_ff.short_ch : CH_U;
         POS_HEX3:   rsp_out_char = hex_char(val[15:12]);
         POS_HEX2:   rsp_out_char = hex_char(val[11:8]);
         POS_HEX1:   rsp_out_char = hex_char(val[7:4]);
         POS_HEX0:   rsp_out_char = hex_char(val[3:0]);
         default:    rsp_out_char = CH_BSLASH;
      endcase
   end

   assign rsp_valid      = busy_ff;
   assign rsp_seq_length = seq_len(cur_ff.kind);
   assign rsp_last       = is_last;

   // sequencer
   always_comb begin
      busy_in = busy_ff;
      pos_in  = pos_ff;
      half_in = half_ff;
      if (load) begin
         busy_in = 1'b1;
         pos_in  = POS_BSLASH;
         half_in = 1'b0;
      end else if (fire) begin
         if (is_last) begin
            busy_in = 1'b0;
         end else if (pos_ff == POS_HEX0) begin
            pos_in  = POS_BSLASH;
            half_in = 1'b1;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pos_ff  <= POS_BSLASH;
         half_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         pos_ff  <= pos_in;
         half_ff <= half_in;
      end
      if (load) begin
         cur_ff <= pop_desc;
      end
   end

endmodule

[rtl/core/json_char_escape_encoder.sv]
// Path: a word passes the input register, then the queue, then the serializer register
// before its first character is presented on rsp_valid.
// Throughput: one character per cycle on the output while rsp_stall is low; a word
// yields 2, 6 or 12 characters. Input words are taken every cycle while the input register
// and the QUEUE_DEPTH-entry queue have room.
// Reset: synchronous, active high; empties the queue and the serializer, no clearing pass.
module json_char_escape_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [20:0] req_code_point,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [6:0]  rsp_out_char,
   output logic [3:0]  rsp_seq_length,
   output logic        rsp_last
);
   import jce_pkg::*;

   queue_status_type q_status;
   desc_type         push_desc, pop_desc;
   logic             push, pop;

   jce_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .q_status       (q_status),
      .push           (push),
      .push_desc      (push_desc)
   );

   jce_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_desc (push_desc),
      .pop       (pop),
      .pop_desc  (pop_desc),
      .q_status  (q_status)
   );

   jce_back u_back (
      .clock          (clock),
      .reset          (reset),
      .q_status       (q_status),
      .pop_desc       (pop_desc),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_seq_length (rsp_seq_length),
      .rsp_last       (rsp_last)
   );

   // a sequence runs without gaps once started
   a_no_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last |=> rsp_valid)
      else $error("sequence interrupted");

   // a sequence that follows straight on a finished one opens with a backslash
   a_open_bslash: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && rsp_last) ##1 rsp_valid |-> rsp_out_char == CH_BSLASH)
      else $error("sequence does not start with backslash");

   // queue cannot be full and empty at once
   a_queue_sane: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("queue full and empty");

endmodule

[tb/sv/json_char_escape_encoder_chk.sv]
`timescale 1ns / 100ps

// Watches both channels of the escape encoder, predicts the character
// stream for every accepted code point word and compares it in order.
module json_char_escape_encoder_chk (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [20:0] req_code_point,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [6:0]  rsp_out_char,
   input  logic [3:0]  rsp_seq_length,
   input  logic        rsp_last,
   output int          err_count,
   output int          chars_pending,
   output int          words_seen,
   output int          chars_seen,
   output int          short_seqs,
   output int          u16_seqs,
   output int          pair_seqs
);
   import jce_pkg::*;

   typedef struct packed {
      logic [6:0] ch;
      logic [3:0] len;
      logic       last;
   } esc_char_type;

   // characters still owed by the block, oldest first
   esc_char_type expected_chars[$];

   int fail_tally  = 0;
   int word_tally  = 0;
   int char_tally  = 0;
   int short_tally = 0;
   int u16_tally   = 0;
   int pair_tally  = 0;

   task automatic report_mismatch(input string what);
      $display("%0t ns: mismatch: %s", $time, what);
      fail_tally++;
   endtask

   // upper-case hex digit
   function automatic logic [6:0] hex_digit(input logic [3:0] nib);
      if (nib <= 4'd9)
         return 7'h30 + {3'b000, nib};
      return 7'h41 + {3'b000, nib} - 7'd10;
   endfunction

   // \uXXXX group for one 16-bit unit
   task automatic queue_u_escape(input logic [15:0] unit, input logic [3:0] len,
                                 input logic ends_seq);
      expected_chars.push_back('{CH_BSLASH, len, 1'b0});
      expected_chars.push_back('{CH_U, len, 1'b0});
      expected_chars.push_back('{hex_digit(unit[15:12]), len, 1'b0});
      expected_chars.push_back('{hex_digit(unit[11:8]), len, 1'b0});
      expected_chars.push_back('{hex_digit(unit[7:4]), len, 1'b0});
      expected_chars.push_back('{hex_digit(unit[3:0]), len, ends_seq});
   endtask

   // expected escape sequence of one code point
   task automatic predict_escape(input logic [20:0] cp);
      logic [6:0]  short_ch;
      logic [31:0] offset;
      logic [15:0] hi_unit;
      logic [15:0] lo_unit;
      short_ch = 7'h00;
      case (cp)
         CP_QUOTE: short_ch = CH_QUOTE;
         CP_BSL:   short_ch = CH_BSLASH;
         CP_BS:    short_ch = CH_B;
         CP_FF:    short_ch = CH_F;
         CP_LF:    short_ch = CH_N;
         CP_CR:    short_ch = CH_R;
         CP_TAB:   short_ch = CH_T;
         default:  short_ch = 7'h00;
      endcase
      if (short_ch != 7'h00) begin
         expected_chars.push_back('{CH_BSLASH, LEN_SHORT, 1'b0});
         expected_chars.push_back('{short_ch, LEN_SHORT, 1'b1});
         short_tally++;
      end else if (cp <= CP_BMP_MAX) begin
         // lone surrogates and controls land here too
         queue_u_escape(cp[15:0], LEN_U16, 1'b1);
         u16_tally++;
      end else begin
         // beyond 0x10FFFF the high unit runs past 0xDBFF, still four digits
         offset  = {11'b0, cp} - {11'b0, CP_SUPP_BASE};
         hi_unit = SURR_HI_BASE + offset[25:10];
         lo_unit = SURR_LO_BASE + {6'b0, offset[9:0]};
         queue_u_escape(hi_unit, LEN_PAIR, 1'b0);
         queue_u_escape(lo_unit, LEN_PAIR, 1'b1);
         pair_tally++;
      end
   endtask

   // sample both channels at the edge; the tally outputs are registered
   always @(posedge clock) begin
      esc_char_type want;
      if (reset) begin
         expected_chars.delete();
      end else begin
         if (req_valid && !req_stall) begin
            predict_escape(req_code_point);
            word_tally++;
         end
         if (rsp_valid && !rsp_stall) begin
            char_tally++;
            if (expected_chars.size() == 0) begin
               report_mismatch($sformatf("unexpected char 0x%02h, nothing pending",
                                         rsp_out_char));
            end else begin
               want = expected_chars.pop_front();
               if (rsp_out_char !== want.ch)
                  report_mismatch($sformatf("out_char 0x%02h, want 0x%02h",
                                            rsp_out_char, want.ch));
               if (rsp_seq_length !== want.len)
                  report_mismatch($sformatf("seq_length %0d, want %0d",
                                            rsp_seq_length, want.len));
               if (rsp_last !== want.last)
                  report_mismatch($sformatf("last %b, want %b", rsp_last, want.last));
            end
         end
      end
      err_count     <= fail_tally;
      chars_pending <= expected_chars.size();
      words_seen    <= word_tally;
      chars_seen    <= char_tally;
      short_seqs    <= short_tally;
      u16_seqs      <= u16_tally;
      pair_seqs     <= pair_tally;
   end

endmodule

[tb/sv/json_char_escape_encoder_tb.sv]
`timescale 1ns / 100ps

module json_char_escape_encoder_tb;
   import jce_pkg::*;

   localparam int RANDOM_WORDS = 260;
   localparam int SETTLE_CYCLES = 8;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [20:0] req_code_point;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [6:0]  rsp_out_char;
   logic [3:0]  rsp_seq_length;
   logic        rsp_last;

   int err_count;
   int chars_pending;
   int words_seen;
   int chars_seen;
   int short_seqs;
   int u16_seqs;
   int pair_seqs;

   int burst_left;

   json_char_escape_encoder u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_seq_length (rsp_seq_length),
      .rsp_last       (rsp_last)
   );

   json_char_escape_encoder_chk u_chk (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_code_point (req_code_point),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_seq_length (rsp_seq_length),
      .rsp_last       (rsp_last),
      .err_count      (err_count),
      .chars_pending  (chars_pending),
      .words_seen     (words_seen),
      .chars_seen     (chars_seen),
      .short_seqs     (short_seqs),
      .u16_seqs       (u16_seqs),
      .pair_seqs      (pair_seqs)
   );

   // 12 ns clock
   always begin
      clock = 1'b0;
      #6;
      clock = 1'b1;
      #6;
   end

   // idle cycles after a word: mostly none or short, some long, some bursts
   function automatic int pick_gap();
      int r;
      if (burst_left > 0) begin
         burst_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 5) begin
         burst_left = $urandom_range(10, 30);
         return 0;
      end
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(5, 30);
   endfunction

   // random code point, weighted toward the interesting classes
   function automatic logic [20:0] random_code_point();
      int r;
      r = $urandom_range(0, 99);
      if (r < 15) begin
         case ($urandom_range(0, 6))
            0:       return CP_BS;
            1:       return CP_TAB;
            2:       return CP_LF;
            3:       return CP_FF;
            4:       return CP_CR;
            5:       return CP_QUOTE;
            default: return CP_BSL;
         endcase
      end
      if (r < 25)
         return 21'($urandom_range(0, 'h1F));
      if (r < 55)
         return 21'($urandom_range(0, 'hFFFF));
      if (r < 65)
         return 21'($urandom_range('hD800, 'hDFFF));
      if (r < 90)
         return 21'($urandom_range('h10000, 'h10FFFF));
      return 21'($urandom_range(0, 'h1FFFFF));
   endfunction

   // present one word and hold it until taken
   task automatic send_word(input logic [20:0] cp);
      int gap;
      req_valid      <= 1'b1;
      req_code_point <= cp;
      do
         @(posedge clock);
      while (req_stall);
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // hold off the sender until every owed character is out
   task automatic drain();
      req_valid <= 1'b0;
      @(posedge clock);
      while (chars_pending != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // receiver backpressure: open stretches, random stalls, long holds
   initial begin
      int mode;
      forever begin
         mode = $urandom_range(0, 9);
         if (mode < 3) begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(10, 60)) @(posedge clock);
         end else if (mode < 9) begin
            repeat ($urandom_range(10, 40)) begin
               rsp_stall <= ($urandom_range(0, 2) == 0);
               @(posedge clock);
            end
         end else begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(8, 30)) @(posedge clock);
         end
      end
   end

   // stimulus and verdict
   initial begin
      logic [20:0] corner_points [22];
      corner_points = '{21'h000000, CP_BS, CP_TAB, CP_LF, CP_FF, CP_CR, CP_QUOTE, CP_BSL,
                        21'h00000B, 21'h00001F, 21'h000020, 21'h00007F, 21'h00ABCD,
                        21'h00D800, 21'h00DBFF, 21'h00DC00, 21'h00DFFF, 21'h00FFFF,
                        21'h010000, 21'h10FFFF, 21'h110000, 21'h1FFFFF};
      burst_left = 0;
      reset          <= 1'b1;
      req_valid      <= 1'b0;
      req_code_point <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // short escapes, controls, surrogate bounds, plane edges, out of range
      foreach (corner_points[k])
         send_word(corner_points[k]);
      drain();

      for (int k = 0; k < RANDOM_WORDS; k++) begin
         if (k == RANDOM_WORDS / 2)
            drain();
         send_word(random_code_point());
      end
      drain();

      $display("covered %0d code points, %0d characters checked", words_seen, chars_seen);
      $display("sequences: %0d short, %0d single \\u, %0d surrogate pair",
               short_seqs, u16_seqs, pair_seqs);
      if (err_count == 0) begin
         $display("json_char_escape_encoder_tb: done, clean");
      end else begin
         $display("json_char_escape_encoder_tb: done, errors");
      end
      $finish;
   end

   // hard stop if the block hangs
   initial begin
      #5000000;
      $display("timeout: characters still pending");
      $display("json_char_escape_encoder_tb: done, errors");
      $finish;
   end

endmodule

[json_char_escape_encoder.f]
rtl/core/jce_pkg.sv
rtl/core/jce_front.sv
rtl/core/jce_queue.sv
rtl/core/jce_back.sv
rtl/core/json_char_escape_encoder.sv
tb/sv/json_char_escape_encoder_chk.sv
tb/sv/json_char_escape_encoder_tb.sv
